// ----- src/hsr_pkg.sv -----
package hsr_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int INIT_SLOTS  = 4;
    localparam int HANDLE_BITS = 24;
    localparam int CTX_BITS    = 16;

    localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
    localparam int ADDR_BITS  = SLOT_BITS + 1;
    localparam int LOG_W      = $clog2(SLOT_BITS + 1);
    localparam int INIT_LOG   = $clog2(INIT_SLOTS);
    localparam int MAX_LOG    = SLOT_BITS;
    localparam int HDL_W      = 32;
    localparam int ENTRY_W    = CTX_BITS + HDL_W;

    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_LOOKUP   = 1'b1;

    typedef enum logic [1:0] {
        ST_REGISTERED = 2'd0,
        ST_FOUND      = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_GROW_RD,
        S_GROW_WR,
        S_GROW_END
    } state_t;

    typedef struct packed {
        logic accept;
        logic lookup_read;
        logic lookup_done;
        logic scan_take;
        logic scan_next;
        logic grow_start;
        logic grow_read;
        logic grow_write;
        logic grow_commit;
        logic emit_full;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic cnt_last;
        logic can_grow;
    } sts_t;

    // Mask of the slot index bits for a table of 2**lg slots.
    function automatic logic [SLOT_BITS-1:0] slot_mask(input logic [LOG_W-1:0] lg);
        logic [SLOT_BITS-1:0] m;
        for (int b = 0; b < SLOT_BITS; b++)
        begin
            m[b] = (b < int'(lg));
        end
        return m;
    endfunction

endpackage

// ----- src/handle_slot_registry_top.sv -----
// A lookup does one registered read of the slot memory and then one compare. A registration
// scans from the next handle counter, passing each occupied slot in turn, until it finds a
// free slot; when every slot is taken the table doubles if it can still grow, copying each
// occupied old slot into the other memory bank and then switching banks, after which the scan
// runs again; if it cannot grow, the result is full. Each result appears for one cycle with
// result_valid high and cannot be held off. The next item may be started as soon as busy is
// low, including in the cycle in which the previous result is shown.
module handle_slot_registry_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         func,
    input  logic [hsr_pkg::CTX_BITS-1:0] context_id,
    input  logic [hsr_pkg::HDL_W-1:0]    query_handle,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hsr_pkg::HDL_W-1:0]    cfg_data,
    output logic                         result_valid,
    output logic [1:0]                   status,
    output logic [hsr_pkg::HDL_W-1:0]    result_handle,
    output logic [hsr_pkg::CTX_BITS-1:0] found_context
);

    hsr_pkg::cmd_t cmd;
    hsr_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    hsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    hsr_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .context_id    (context_id),
        .query_handle  (query_handle),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .status        (status),
        .result_handle (result_handle),
        .found_context (found_context)
    );

endmodule

// ----- src/hsr_ctrl.sv -----
module hsr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          func,
    input  hsr_pkg::sts_t sts,
    output hsr_pkg::cmd_t cmd,
    output logic          busy
);

    hsr_pkg::state_t state_reg;
    hsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hsr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = (func == hsr_pkg::FUNC_LOOKUP) ? hsr_pkg::S_LOOKUP
                                                                : hsr_pkg::S_SCAN;
                end
            end
            hsr_pkg::S_LOOKUP:
            begin
                state_next = hsr_pkg::S_IDLE;
            end
            hsr_pkg::S_SCAN:
            begin
                priority if (sts.slot_free)
                begin
                    state_next = hsr_pkg::S_IDLE;
                end
                else if (!sts.cnt_last)
                begin
                    state_next = hsr_pkg::S_SCAN;
                end
                else if (sts.can_grow)
                begin
                    state_next = hsr_pkg::S_GROW_RD;
                end
                else
                begin
                    state_next = hsr_pkg::S_IDLE;
                end
            end
            hsr_pkg::S_GROW_RD:
            begin
                state_next = hsr_pkg::S_GROW_WR;
            end
            hsr_pkg::S_GROW_WR:
            begin
                state_next = sts.cnt_last ? hsr_pkg::S_GROW_END : hsr_pkg::S_GROW_RD;
            end
            hsr_pkg::S_GROW_END:
            begin
                state_next = hsr_pkg::S_SCAN;
            end
            default:
            begin
                state_next = hsr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            hsr_pkg::S_IDLE:
            begin
                busy            = 1'b0;
                cmd.accept      = start;
                cmd.lookup_read = start && (func == hsr_pkg::FUNC_LOOKUP);
            end
            hsr_pkg::S_LOOKUP:
            begin
                cmd.lookup_done = 1'b1;
            end
            hsr_pkg::S_SCAN:
            begin
                cmd.scan_take  = sts.slot_free;
                cmd.scan_next  = !sts.slot_free && !sts.cnt_last;
                cmd.grow_start = !sts.slot_free && sts.cnt_last && sts.can_grow;
                cmd.emit_full  = !sts.slot_free && sts.cnt_last && !sts.can_grow;
            end
            hsr_pkg::S_GROW_RD:
            begin
                cmd.grow_read = 1'b1;
            end
            hsr_pkg::S_GROW_WR:
            begin
                cmd.grow_write = 1'b1;
            end
            hsr_pkg::S_GROW_END:
            begin
                cmd.grow_commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- src/hsr_dpath.sv -----
module hsr_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hsr_pkg::cmd_t                cmd,
    output hsr_pkg::sts_t                sts,
    input  logic [hsr_pkg::CTX_BITS-1:0] context_id,
    input  logic [hsr_pkg::HDL_W-1:0]    query_handle,
    input  logic                         cfg_valid,
    input  logic [hsr_pkg::HDL_W-1:0]    cfg_data,
    output logic                         result_valid,
    output logic [1:0]                   status,
    output logic [hsr_pkg::HDL_W-1:0]    result_handle,
    output logic [hsr_pkg::CTX_BITS-1:0] found_context
);

    logic [hsr_pkg::HDL_W-1:0]       harbor_reg;
    logic [hsr_pkg::MAX_SLOTS-1:0]   valid_reg;
    logic [hsr_pkg::MAX_SLOTS-1:0]   tmp_valid_reg;
    logic                            bank_reg;
    logic [hsr_pkg::LOG_W-1:0]       size_log_reg;
    logic [hsr_pkg::HANDLE_BITS-1:0] next_reg;
    logic [hsr_pkg::SLOT_BITS-1:0]   cnt_reg;
    logic [hsr_pkg::CTX_BITS-1:0]    ctx_reg;
    logic [hsr_pkg::HDL_W-1:0]       query_reg;
    logic [hsr_pkg::ENTRY_W-1:0]     rd_data_reg;
    logic                            out_valid_reg;
    hsr_pkg::status_t                status_reg;
    logic [hsr_pkg::HDL_W-1:0]       handle_out_reg;
    logic [hsr_pkg::CTX_BITS-1:0]    ctx_out_reg;

    logic [hsr_pkg::ENTRY_W-1:0] mem [2**hsr_pkg::ADDR_BITS];

    logic [hsr_pkg::SLOT_BITS-1:0]   size_mask;
    logic [hsr_pkg::SLOT_BITS-1:0]   grow_mask;
    logic [hsr_pkg::HANDLE_BITS-1:0] raw;
    logic [hsr_pkg::SLOT_BITS-1:0]   scan_slot;
    logic [hsr_pkg::HDL_W-1:0]       new_handle;
    logic [hsr_pkg::HDL_W-1:0]       rd_handle;
    logic [hsr_pkg::CTX_BITS-1:0]    rd_ctx;
    logic [hsr_pkg::SLOT_BITS-1:0]   grow_dest;
    logic [hsr_pkg::SLOT_BITS-1:0]   lookup_slot;
    logic                            found;
    logic                            mem_we;
    logic [hsr_pkg::ADDR_BITS-1:0]   mem_waddr;
    logic [hsr_pkg::ENTRY_W-1:0]     mem_wdata;
    logic                            mem_re;
    logic [hsr_pkg::ADDR_BITS-1:0]   mem_raddr;

    assign size_mask   = hsr_pkg::slot_mask(size_log_reg);
    assign grow_mask   = {size_mask[hsr_pkg::SLOT_BITS-2:0], 1'b1};
    assign raw         = next_reg + hsr_pkg::HANDLE_BITS'(cnt_reg);
    assign scan_slot   = raw[hsr_pkg::SLOT_BITS-1:0] & size_mask;
    assign new_handle  = hsr_pkg::HDL_W'(raw) | harbor_reg;
    assign rd_handle   = rd_data_reg[hsr_pkg::HDL_W-1:0];
    assign rd_ctx      = rd_data_reg[hsr_pkg::ENTRY_W-1:hsr_pkg::HDL_W];
    assign grow_dest   = rd_handle[hsr_pkg::SLOT_BITS-1:0] & grow_mask;
    assign lookup_slot = query_handle[hsr_pkg::SLOT_BITS-1:0] & size_mask;
    assign found       = valid_reg[cnt_reg] && (rd_handle == query_reg);

    assign sts.slot_free = !valid_reg[scan_slot];
    assign sts.cnt_last  = (cnt_reg == size_mask);
    assign sts.can_grow  = (int'(size_log_reg) < hsr_pkg::MAX_LOG)
                        && (int'(size_log_reg) < hsr_pkg::HANDLE_BITS);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {bank_reg, scan_slot};
        mem_wdata = {ctx_reg, new_handle};
        if (cmd.scan_take)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.grow_write && valid_reg[cnt_reg])
        begin
            mem_we    = 1'b1;
            mem_waddr = {!bank_reg, grow_dest};
            mem_wdata = rd_data_reg;
        end
    end

    assign mem_re    = cmd.lookup_read || cmd.grow_read;
    assign mem_raddr = cmd.lookup_read ? {bank_reg, lookup_slot} : {bank_reg, cnt_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harbor_reg    <= '0;
            valid_reg     <= '0;
            tmp_valid_reg <= '0;
            bank_reg      <= 1'b0;
            size_log_reg  <= hsr_pkg::LOG_W'(hsr_pkg::INIT_LOG);
            next_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                harbor_reg <= cfg_data;
            end
            out_valid_reg <= cmd.lookup_done || cmd.scan_take || cmd.emit_full;

            if (cmd.accept)
            begin
                cnt_reg <= cmd.lookup_read ? lookup_slot : '0;
            end
            else if (cmd.scan_next || cmd.grow_write)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.grow_start || cmd.grow_commit)
            begin
                cnt_reg <= '0;
            end

            if (cmd.scan_take)
            begin
                valid_reg[scan_slot] <= 1'b1;
                next_reg             <= raw + 1'b1;
            end

            if (cmd.grow_start)
            begin
                tmp_valid_reg <= '0;
            end
            else if (cmd.grow_write && valid_reg[cnt_reg])
            begin
                tmp_valid_reg[grow_dest] <= 1'b1;
            end

            if (cmd.grow_commit)
            begin
                valid_reg    <= tmp_valid_reg;
                bank_reg     <= !bank_reg;
                size_log_reg <= size_log_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ctx_reg   <= context_id;
            query_reg <= query_handle;
        end
        if (cmd.lookup_done)
        begin
            status_reg     <= found ? hsr_pkg::ST_FOUND : hsr_pkg::ST_NOT_FOUND;
            handle_out_reg <= query_reg;
            ctx_out_reg    <= found ? rd_ctx : '0;
        end
        else if (cmd.scan_take)
        begin
            status_reg     <= hsr_pkg::ST_REGISTERED;
            handle_out_reg <= new_handle;
            ctx_out_reg    <= ctx_reg;
        end
        else if (cmd.emit_full)
        begin
            status_reg     <= hsr_pkg::ST_FULL;
            handle_out_reg <= '0;
            ctx_out_reg    <= '0;
        end
    end

    assign result_valid  = out_valid_reg;
    assign status        = status_reg;
    assign result_handle = handle_out_reg;
    assign found_context = ctx_out_reg;

endmodule
